// ----- design/lsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, constants and helpers of the line segment window clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  // coordinate width and derived widths
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int MUL_W      = 2 * COORD_BITS;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  // accept edge to result strobe, in clock cycles
  localparam int LATENCY    = COORD_BITS + 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic        [MUL_W-1:0]      wide_t;

  typedef enum logic [1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_TOP    = 2'd1,
    REG_WIN_RIGHT  = 2'd2,
    REG_WIN_BOTTOM = 2'd3
  } cfg_reg_e;

  // parameter t = n / d, d positive
  typedef struct packed {
    diff_t n;
    mag_t  d;
  } ratio_t;

  // entry and exit candidates of one axis
  typedef struct packed {
    ratio_t ent;
    ratio_t ext;
    logic   rej;
  } axis_t;

  // classified segment handed from front to back
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    diff_t  dx;
    diff_t  dy;
    axis_t  ax;
    axis_t  ay;
  } item_t;

  // entry and exit candidates of one axis against its two window edges
  function automatic axis_t classify_axis(coord_t s, coord_t e, coord_t lo, coord_t hi);
    axis_t r;
    diff_t del;
    diff_t dl;
    diff_t dh;
    diff_t en;
    diff_t xn;
    mag_t  dd;
    del = diff_t'(e) - diff_t'(s);
    dl  = diff_t'(s) - diff_t'(lo);
    dh  = diff_t'(hi) - diff_t'(s);
    r.rej   = 1'b0;
    r.ent.n = '0;
    r.ent.d = mag_t'(1);
    r.ext.n = diff_t'(1);
    r.ext.d = mag_t'(1);
    en = '0;
    xn = '0;
    dd = mag_t'(1);
    if (del == '0) begin
      r.rej = (dl < 0) || (dh < 0);
    end else begin
      if (del > 0) begin
        en = -dl;
        xn = dh;
        dd = mag_t'(del);
      end else begin
        en = -dh;
        xn = dl;
        dd = mag_t'(-del);
      end
      // entry at or before zero keeps t0 = 0
      if (en > 0) begin
        r.ent.n = en;
        r.ent.d = dd;
      end
      // exit at or after one keeps t1 = 1
      if (xn < $signed({1'b0, dd})) begin
        r.ext.n = xn;
        r.ext.d = dd;
      end
    end
    return r;
  endfunction

  // signed n times positive d, exact
  function automatic prod_t mul_nd(diff_t n, mag_t d);
    return prod_t'(n) * prod_t'($signed({1'b0, d}));
  endfunction

  function automatic mag_t mag_of(diff_t v);
    return (v < 0) ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage

`default_nettype wire

// ----- design/lsc_front.sv -----
// ----------------------------------------------------------------------------
// lsc_front
// Window registers, request intake and per-axis classification.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_front import lsc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  wire coord_t   start_x_i,
  input  wire coord_t   start_y_i,
  input  wire coord_t   end_x_i,
  input  wire coord_t   end_y_i,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire cfg_reg_e cfg_index_i,
  input  wire coord_t   cfg_data_i,
  input  wire logic     full_i,
  output logic          push_o,
  output item_t         item_o
);

  coord_t win_left_q, win_top_q, win_right_q, win_bottom_q;
  logic   f_valid_q, f_valid_d;
  item_t  f_item_q;
  logic   accept;

  assign cfg_ready_o = 1'b1;

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= coord_t'(0);
      win_top_q    <= coord_t'(0);
      win_right_q  <= coord_t'(1023);
      win_bottom_q <= coord_t'(767);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WIN_LEFT:   win_left_q   <= cfg_data_i;
        REG_WIN_TOP:    win_top_q    <= cfg_data_i;
        REG_WIN_RIGHT:  win_right_q  <= cfg_data_i;
        REG_WIN_BOTTOM: win_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // intake handshake
  assign busy_o = f_valid_q && full_i;
  assign accept = start_i && !busy_o;
  assign push_o = f_valid_q && !full_i;

  always_comb begin
    f_valid_d = f_valid_q;
    if (push_o) f_valid_d = 1'b0;
    if (accept) f_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  // classify the request against both axes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_item_q.sx <= start_x_i;
      f_item_q.sy <= start_y_i;
      f_item_q.ex <= end_x_i;
      f_item_q.ey <= end_y_i;
      f_item_q.dx <= diff_t'(end_x_i) - diff_t'(start_x_i);
      f_item_q.dy <= diff_t'(end_y_i) - diff_t'(start_y_i);
      f_item_q.ax <= classify_axis(start_x_i, end_x_i, win_left_q, win_right_q);
      f_item_q.ay <= classify_axis(start_y_i, end_y_i, win_top_q, win_bottom_q);
    end
  end

  assign item_o = f_item_q;

endmodule

`default_nettype wire

// ----- design/lsc_fifo.sv -----
// ----------------------------------------------------------------------------
// lsc_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_fifo import lsc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o
);

  item_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     count_q;
  logic                pop;

  // back side takes every request as soon as it is there
  assign valid_o = (count_q != '0);
  assign pop     = valid_o;
  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)    rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/lsc_div.sv -----
// ----------------------------------------------------------------------------
// lsc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_div import lsc_pkg::*; (
  input  wire logic  clk_i,
  input  wire wide_t num_i,
  input  wire mag_t  den_i,
  output mag_t       quo_o,
  output logic       rnz_o
);

  // quotient is known to fit, so the upper half starts as remainder
  mag_t                rem_q [COORD_BITS];
  mag_t                low_q [COORD_BITS];
  mag_t                quo_q [COORD_BITS];
  mag_t                den_q [COORD_BITS];
  mag_t                rem_in [COORD_BITS];
  mag_t                low_in [COORD_BITS];
  mag_t                quo_in [COORD_BITS];
  mag_t                den_in [COORD_BITS];
  logic [COORD_BITS:0] trial [COORD_BITS];
  logic                ge [COORD_BITS];

  // stage inputs
  always_comb begin
    for (int i = 0; i < COORD_BITS; i++) begin
      if (i == 0) begin
        rem_in[i] = num_i[MUL_W-1:COORD_BITS];
        low_in[i] = num_i[COORD_BITS-1:0];
        quo_in[i] = '0;
        den_in[i] = den_i;
      end else begin
        rem_in[i] = rem_q[i-1];
        low_in[i] = low_q[i-1];
        quo_in[i] = quo_q[i-1];
        den_in[i] = den_q[i-1];
      end
    end
  end

  // one trial subtraction per stage
  always_comb begin
    for (int i = 0; i < COORD_BITS; i++) begin
      trial[i] = {rem_in[i], low_in[i][COORD_BITS-1]};
      ge[i]    = trial[i] >= {1'b0, den_in[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < COORD_BITS; i++) begin
      rem_q[i] <= ge[i] ? mag_t'(trial[i] - {1'b0, den_in[i]}) : mag_t'(trial[i]);
      low_q[i] <= low_in[i] << 1;
      quo_q[i] <= {quo_in[i][COORD_BITS-2:0], ge[i]};
      den_q[i] <= den_in[i];
    end
  end

  assign quo_o = quo_q[COORD_BITS-1];
  assign rnz_o = |rem_q[COORD_BITS-1];

endmodule

`default_nettype wire

// ----- design/lsc_back.sv -----
// ----------------------------------------------------------------------------
// lsc_back
// Picks entry and exit parameters, runs the accept test and interpolates.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_back import lsc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire item_t item_i,
  output logic       done_o,
  output logic       visible_o,
  output coord_t     clip_start_x_o,
  output coord_t     clip_start_y_o,
  output coord_t     clip_end_x_o,
  output coord_t     clip_end_y_o
);

  typedef struct packed {
    logic   vis;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   negx;
    logic   negy;
  } side_t;

  typedef logic signed [COORD_BITS+1:0] ext_t;

  // truncate s + qm (+ fraction) toward zero, with sign of the step
  function automatic coord_t lerp_fix(coord_t s, logic neg, mag_t qm, logic rnz);
    ext_t qe;
    ext_t qn;
    ext_t base;
    qe = $signed({2'b00, qm});
    qn = neg ? (-qe - ext_t'(rnz)) : qe;
    base = ext_t'(s) + qn;
    if (rnz && (base < 0)) base = base + ext_t'(1);
    return coord_t'(base);
  endfunction

  // stage 1: cross products of the candidates
  logic   v1_q, v2_q, v3_q;
  item_t  i1_q, i2_q;
  prod_t  pe_x_q, pe_y_q, px_x_q, px_y_q;
  ratio_t t0_q, t1_q;
  logic   rej2_q;
  // stage 3
  prod_t  p01_q, p10_q;
  logic   rej3_q;
  wide_t  m_q [4];
  mag_t   dv_q [4];
  coord_t sx3_q, sy3_q, ex3_q, ey3_q;
  logic   negx3_q, negy3_q;
  // divider side band
  logic   sv_q [COORD_BITS];
  side_t  sd_q [COORD_BITS];
  mag_t   quo [4];
  logic   rnz [4];
  side_t  last;

  always_ff @(posedge clk_i) begin
    i1_q   <= item_i;
    pe_x_q <= mul_nd(item_i.ax.ent.n, item_i.ay.ent.d);
    pe_y_q <= mul_nd(item_i.ay.ent.n, item_i.ax.ent.d);
    px_x_q <= mul_nd(item_i.ax.ext.n, item_i.ay.ext.d);
    px_y_q <= mul_nd(item_i.ay.ext.n, item_i.ax.ext.d);
  end

  // stage 2: latest entry, earliest exit
  always_ff @(posedge clk_i) begin
    i2_q   <= i1_q;
    t0_q   <= (pe_x_q >= pe_y_q) ? i1_q.ax.ent : i1_q.ay.ent;
    t1_q   <= (px_x_q <= px_y_q) ? i1_q.ax.ext : i1_q.ay.ext;
    rej2_q <= i1_q.ax.rej || i1_q.ay.rej;
  end

  // stage 3: order test products and interpolation products
  always_ff @(posedge clk_i) begin
    p01_q   <= mul_nd(t0_q.n, t1_q.d);
    p10_q   <= mul_nd(t1_q.n, t0_q.d);
    rej3_q  <= rej2_q;
    m_q[0]  <= wide_t'(mag_t'(t0_q.n)) * wide_t'(mag_of(i2_q.dx));
    m_q[1]  <= wide_t'(mag_t'(t0_q.n)) * wide_t'(mag_of(i2_q.dy));
    m_q[2]  <= wide_t'(mag_t'(t1_q.n)) * wide_t'(mag_of(i2_q.dx));
    m_q[3]  <= wide_t'(mag_t'(t1_q.n)) * wide_t'(mag_of(i2_q.dy));
    dv_q[0] <= t0_q.d;
    dv_q[1] <= t0_q.d;
    dv_q[2] <= t1_q.d;
    dv_q[3] <= t1_q.d;
    sx3_q   <= i2_q.sx;
    sy3_q   <= i2_q.sy;
    ex3_q   <= i2_q.ex;
    ey3_q   <= i2_q.ey;
    negx3_q <= i2_q.dx < 0;
    negy3_q <= i2_q.dy < 0;
  end

  // four dividers, one per output coordinate
  for (genvar g = 0; g < 4; g++) begin : g_div
    lsc_div u_div (
      .clk_i (clk_i),
      .num_i (m_q[g]),
      .den_i (dv_q[g]),
      .quo_o (quo[g]),
      .rnz_o (rnz[g])
    );
  end

  // side band payload follows the divider
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < COORD_BITS; i++) begin
      if (i == 0) begin
        sd_q[i].vis  <= !rej3_q && !(p01_q > p10_q);
        sd_q[i].sx   <= sx3_q;
        sd_q[i].sy   <= sy3_q;
        sd_q[i].ex   <= ex3_q;
        sd_q[i].ey   <= ey3_q;
        sd_q[i].negx <= negx3_q;
        sd_q[i].negy <= negy3_q;
      end else begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int i = 0; i < COORD_BITS; i++) sv_q[i] <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      sv_q[0] <= v3_q;
      for (int i = 1; i < COORD_BITS; i++) sv_q[i] <= sv_q[i-1];
      done_o <= sv_q[COORD_BITS-1];
    end
  end

  assign last = sd_q[COORD_BITS-1];

  // result register
  always_ff @(posedge clk_i) begin
    visible_o <= last.vis;
    if (last.vis) begin
      clip_start_x_o <= lerp_fix(last.sx, last.negx, quo[0], rnz[0]);
      clip_start_y_o <= lerp_fix(last.sy, last.negy, quo[1], rnz[1]);
      clip_end_x_o   <= lerp_fix(last.sx, last.negx, quo[2], rnz[2]);
      clip_end_y_o   <= lerp_fix(last.sy, last.negy, quo[3], rnz[3]);
    end else begin
      clip_start_x_o <= last.sx;
      clip_start_y_o <= last.sy;
      clip_end_x_o   <= last.ex;
      clip_end_y_o   <= last.ey;
    end
  end

endmodule

`default_nettype wire

// ----- design/line_segment_window_clipper.sv -----
// ----------------------------------------------------------------------------
// line_segment_window_clipper
// Liang-Barsky clipping of integer segments against a programmable window.
// ----------------------------------------------------------------------------
// A segment request is taken whenever start_i is high and busy_o is low; one
// request can enter every clock cycle. Its result appears on done_o and the
// clip ports for exactly one cycle, in request order, after the front
// register, the queue and the back pipeline, which is mostly the four
// pipelined restoring dividers, one quotient bit per stage, that produce the
// clipped coordinates. The window registers are written through the cfg
// port (always ready) and must only change while no request is in flight.
`default_nettype none

module line_segment_window_clipper import lsc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  wire coord_t   start_x_i,
  input  wire coord_t   start_y_i,
  input  wire coord_t   end_x_i,
  input  wire coord_t   end_y_i,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire cfg_reg_e cfg_index_i,
  input  wire coord_t   cfg_data_i,
  output logic          done_o,
  output logic          visible_o,
  output coord_t        clip_start_x_o,
  output coord_t        clip_start_y_o,
  output coord_t        clip_end_x_o,
  output coord_t        clip_end_y_o
);

  logic  full, push, q_valid;
  item_t f_item, q_item;

  // intake and classification
  lsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (f_item)
  );

  // decoupling queue
  lsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // clipping pipeline
  lsc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (q_item),
    .done_o         (done_o),
    .visible_o      (visible_o),
    .clip_start_x_o (clip_start_x_o),
    .clip_start_y_o (clip_start_y_o),
    .clip_end_x_o   (clip_end_x_o),
    .clip_end_y_o   (clip_end_y_o)
  );

endmodule

`default_nettype wire

// ----- design/lsc_checker.sv -----
// ----------------------------------------------------------------------------
// lsc_checker
// Port level checks of the clipper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_checker import lsc_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic cfg_ready_o,
  input wire logic done_o
);

  // config port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("cfg port not ready");

  // queue drains every cycle, so intake never stalls
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("unexpected busy");

  // every accepted request yields one result, taken at the edge that ends the strobe
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(LATENCY+1) done_o)
    else $error("missing result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o && rst_ni, LATENCY+1))
    else $error("spurious result");

endmodule

bind line_segment_window_clipper lsc_checker u_lsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .cfg_ready_o (cfg_ready_o),
  .done_o      (done_o)
);

`default_nettype wire
